// ===== src/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants for the set-associative LRU cache tag model.
// ----------------------------------------------------------------------------
package salc_pkg;

    localparam int MAX_SET_BITS_DEF = 8;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int ADDR_BITS_DEF    = 64;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_STORE  = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;
    localparam logic [1:0] OP_UNDEF  = 2'd3;

    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_FILL  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    localparam logic [1:0] REG_SET_BITS = 2'd0;
    localparam logic [1:0] REG_OFF_BITS = 2'd1;
    localparam logic [1:0] REG_WAYS     = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_WRITE,
        ST_RESULT
    } state_t;

endpackage

// ===== src/salc_ram.sv =====
// ----------------------------------------------------------------------------
// salc_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== src/set_associative_lru_cache_model_core.sv =====
// ----------------------------------------------------------------------------
// set_associative_lru_cache_model_core
// Tag-only set-associative cache with true LRU replacement and totals.
// ----------------------------------------------------------------------------
// One access reads the ways of a set one per cycle through a shared tag
// compare, then reads and writes back each way in turn to age ranks; the
// next input word is taken only once its last result word is registered.
// A modify runs its second access right after the first result is
// registered. The second result waits while the first one is not yet taken.
// After reset a clearing pass initializes the line store; no word is
// accepted meanwhile. Results sit in an output register, so a new input
// word may be taken while the last result word still waits.
module set_associative_lru_cache_model_core
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = MAX_WAYS_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // [1:0] op, [65:2] address, [71:66] zero
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // [1:0] outcome, [33:2] hit_total,
                                    // [65:34] miss_total, [97:66] eviction_total
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    localparam int WB    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SB    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int DEPTH = 1 << (MAX_SET_BITS + WB);
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = 1 + ADDR_BITS + WB;   // valid, tag, rank
    localparam int WCW   = $clog2(MAX_WAYS + 1);

    state_t state_reg, state_next;

    logic [3:0] set_bits_reg;
    logic [5:0] off_bits_reg;
    logic [3:0] ways_reg;

    logic [ADDR_BITS-1:0] tag_reg, tag_next;
    logic [SB-1:0]        set_reg, set_next;
    logic                 second_reg, second_next;
    logic [WCW-1:0]       way_reg, way_next;
    logic [WCW-1:0]       nways;
    logic                 rd_valid_reg, rd_valid_next;

    logic                 hit_reg, hit_next;
    logic [WB-1:0]        hit_way_reg, hit_way_next;
    logic [WB-1:0]        hit_rank_reg, hit_rank_next;
    logic                 inv_reg, inv_next;
    logic [WB-1:0]        inv_way_reg, inv_way_next;
    logic [WB-1:0]        inv_rank_reg, inv_rank_next;
    logic [WB-1:0]        vic_way_reg, vic_way_next;
    logic [WB-1:0]        vic_rank_reg, vic_rank_next;
    logic [WB-1:0]        sel_way;
    logic [WB-1:0]        sel_rank_reg, sel_rank_next;

    logic [31:0] hits_reg, hits_next, miss_reg, miss_next, evict_reg, evict_next;
    logic [1:0]  outcome_reg, outcome_next;
    logic        mvalid_reg, mvalid_next;
    logic        mlast_reg, mlast_next;
    logic [103:0] mdata_reg, mdata_next;

    logic [AW:0]    clr_reg, clr_next;
    logic           ram_we;
    logic [AW-1:0]  ram_addr;
    logic [LW-1:0]  ram_wdata, ram_rdata;

    logic                 l_valid;
    logic [ADDR_BITS-1:0] l_tag;
    logic [WB-1:0]        l_rank;
    logic [WB-1:0]        rd_way_reg, rd_way_next;

    logic [1:0]           in_op;
    logic [ADDR_BITS-1:0] in_addr;
    logic [3:0]           s_eff;
    logic [6:0]           sb_sum;
    logic [ADDR_BITS-1:0] shifted_set;
    logic [ADDR_BITS-1:0] set_mask;

    salc_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_lines (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    assign {l_valid, l_tag, l_rank} = ram_rdata;

    // configuration
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg <= '0;
            off_bits_reg <= '0;
            ways_reg     <= 4'd1;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_SET_BITS: set_bits_reg <= pwdata[3:0];
                REG_OFF_BITS: off_bits_reg <= pwdata[5:0];
                REG_WAYS:     ways_reg     <= pwdata[3:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (paddr[3:2])
            REG_SET_BITS: prdata = {28'd0, set_bits_reg};
            REG_OFF_BITS: prdata = {26'd0, off_bits_reg};
            REG_WAYS:     prdata = {28'd0, ways_reg};
            default:      prdata = '0;
        endcase
    end

    always_comb
    begin
        if (ways_reg == 4'd0)
            nways = WCW'(1);
        else if (32'(ways_reg) > MAX_WAYS)
            nways = WCW'(MAX_WAYS);
        else
            nways = WCW'(ways_reg);
    end

    // address split
    assign in_op   = s_tdata[1:0];
    assign in_addr = s_tdata[ADDR_BITS+1:2];
    assign s_eff   = (32'(set_bits_reg) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : set_bits_reg;
    assign sb_sum  = 7'(s_eff) + 7'(off_bits_reg);
    assign shifted_set = in_addr >> off_bits_reg;
    assign set_mask    = ~({ADDR_BITS{1'b1}} << s_eff);

    assign sel_way = hit_reg ? hit_way_reg : (inv_reg ? inv_way_reg : vic_way_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            hits_reg      <= '0;
            miss_reg      <= '0;
            evict_reg     <= '0;
            mvalid_reg    <= 1'b0;
            second_reg    <= 1'b0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            hits_reg      <= hits_next;
            miss_reg      <= miss_next;
            evict_reg     <= evict_next;
            mvalid_reg    <= mvalid_next;
            second_reg    <= second_next;
            rd_valid_reg  <= rd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg       <= tag_next;
        set_reg       <= set_next;
        way_reg       <= way_next;
        rd_way_reg    <= rd_way_next;
        hit_reg       <= hit_next;
        hit_way_reg   <= hit_way_next;
        hit_rank_reg  <= hit_rank_next;
        inv_reg       <= inv_next;
        inv_way_reg   <= inv_way_next;
        inv_rank_reg  <= inv_rank_next;
        vic_way_reg   <= vic_way_next;
        vic_rank_reg  <= vic_rank_next;
        sel_rank_reg  <= sel_rank_next;
        outcome_reg   <= outcome_next;
        mlast_reg     <= mlast_next;
        mdata_reg     <= mdata_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:  if (clr_reg == (AW+1)'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:   if (s_tvalid && in_op != OP_UNDEF) state_next = ST_SCAN;
            ST_SCAN:   if (rd_valid_reg && (32'(rd_way_reg) + 1 == 32'(nways)))
                           state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_WRITE;
            ST_WRITE:  if (rd_valid_reg && (32'(rd_way_reg) + 1 == 32'(nways)))
                           state_next = ST_RESULT;
            ST_RESULT: if (!mvalid_reg)
                           state_next = second_reg ? ST_SCAN : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        clr_next       = clr_reg;
        tag_next       = tag_reg;
        set_next       = set_reg;
        second_next    = second_reg;
        way_next       = way_reg;
        rd_way_next    = rd_way_reg;
        rd_valid_next  = 1'b0;
        hit_next       = hit_reg;
        hit_way_next   = hit_way_reg;
        hit_rank_next  = hit_rank_reg;
        inv_next       = inv_reg;
        inv_way_next   = inv_way_reg;
        inv_rank_next  = inv_rank_reg;
        vic_way_next   = vic_way_reg;
        vic_rank_next  = vic_rank_reg;
        sel_rank_next  = sel_rank_reg;
        hits_next      = hits_reg;
        miss_next      = miss_reg;
        evict_next     = evict_reg;
        outcome_next   = outcome_reg;
        mvalid_next    = mvalid_reg && !m_tready;
        mlast_next     = mlast_reg;
        mdata_next     = mdata_reg;
        ram_we         = 1'b0;
        ram_addr       = AW'({set_reg, way_reg[WB-1:0]});
        ram_wdata      = ram_rdata;
        s_tready       = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                // rank starts as the way index, the low address bits
                ram_we    = 1'b1;
                ram_addr  = clr_reg[AW-1:0];
                ram_wdata = {1'b0, {ADDR_BITS{1'b0}}, clr_reg[WB-1:0]};
                clr_next  = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    set_next       = SB'(shifted_set & set_mask);
                    tag_next       = (sb_sum >= 7'd64) ? '0 : (in_addr >> sb_sum);
                    second_next    = (in_op == OP_MODIFY);
                    way_next       = '0;
                    hit_next       = 1'b0;
                    inv_next       = 1'b0;
                    vic_way_next   = '0;
                    vic_rank_next  = '0;
                end
            end
            ST_SCAN:
            begin
                // issue read for way_reg, compare previous read
                if (32'(way_reg) < 32'(nways))
                begin
                    ram_addr      = AW'({set_reg, way_reg[WB-1:0]});
                    rd_way_next   = way_reg[WB-1:0];
                    rd_valid_next = 1'b1;
                    way_next      = way_reg + 1'b1;
                end
                if (rd_valid_reg)
                begin
                    if (l_valid && l_tag == tag_reg && !hit_reg)
                    begin
                        hit_next      = 1'b1;
                        hit_way_next  = rd_way_reg;
                        hit_rank_next = l_rank;
                    end
                    if (!l_valid && !inv_reg)
                    begin
                        inv_next      = 1'b1;
                        inv_way_next  = rd_way_reg;
                        inv_rank_next = l_rank;
                    end
                    if (rd_way_reg == '0 || l_rank > vic_rank_reg)
                    begin
                        vic_way_next  = rd_way_reg;
                        vic_rank_next = l_rank;
                    end
                end
            end
            ST_UPDATE:
            begin
                // rank of the way that becomes most recently used
                way_next = '0;
                if (hit_reg)
                begin
                    hits_next    = (hits_reg == '1) ? hits_reg : hits_reg + 1'b1;
                    outcome_next = OUT_HIT;
                end
                else
                begin
                    miss_next = (miss_reg == '1) ? miss_reg : miss_reg + 1'b1;
                    if (inv_reg)
                        outcome_next = OUT_FILL;
                    else
                    begin
                        evict_next   = (evict_reg == '1) ? evict_reg : evict_reg + 1'b1;
                        outcome_next = OUT_EVICT;
                    end
                end
                sel_rank_next = hit_reg ? hit_rank_reg : (inv_reg ? inv_rank_reg : vic_rank_reg);
                ram_addr = AW'({set_reg, sel_way});
                rd_way_next   = sel_way;
                rd_valid_next = 1'b0;
            end
            ST_WRITE:
            begin
                // read a way, then write it back aged, promoted or unchanged
                if (32'(way_reg) < 32'(nways) && !ram_we)
                begin
                    ram_addr      = AW'({set_reg, way_reg[WB-1:0]});
                    rd_way_next   = way_reg[WB-1:0];
                    rd_valid_next = 1'b1;
                    way_next      = way_reg + 1'b1;
                end
                if (rd_valid_reg)
                begin
                    ram_we   = 1'b1;
                    ram_addr = AW'({set_reg, rd_way_reg});
                    rd_valid_next = 1'b0;
                    way_next      = way_reg;
                    rd_way_next   = rd_way_reg;
                    if (rd_way_reg == sel_way)
                        ram_wdata = {1'b1, (hit_reg ? l_tag : tag_reg), WB'(0)};
                    else if (l_rank < sel_rank_reg)
                        ram_wdata = {l_valid, l_tag, l_rank + 1'b1};
                    else
                        ram_wdata = ram_rdata;
                end
            end
            ST_RESULT:
            begin
                if (!mvalid_reg)
                begin
                    mvalid_next  = 1'b1;
                    mlast_next   = !second_reg;
                    mdata_next   = {6'd0, evict_reg, miss_reg, hits_reg, outcome_reg};
                    second_next  = 1'b0;
                    way_next     = '0;
                    hit_next     = 1'b0;
                    inv_next     = 1'b0;
                    vic_way_next = '0;
                    vic_rank_next = '0;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = mvalid_reg;
    assign m_tlast  = mlast_reg;
    assign m_tdata  = mdata_reg;
endmodule

// ===== src/salc_checker.sv =====
// ----------------------------------------------------------------------------
// salc_checker
// Port-level checks for the cache model core, bound to the top level.
// ----------------------------------------------------------------------------
module salc_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic         m_tlast
);
    // hit total never decreases
    a_hits_mono: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> !m_tvalid || m_tdata[33:2] >= $past(m_tdata[33:2]))
        else $error("hit total decreased");

    a_evict_le_miss: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[97:66] <= m_tdata[65:34])
        else $error("evictions exceed misses");

    // second access of a modify still runs while its first word waits
    a_no_take_mid_item: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready in the middle of an item");

    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");
endmodule

bind set_associative_lru_cache_model_core salc_checker u_salc_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the set-associative LRU cache tag model: random and
// directed accesses across several cache geometries, each result word checked
// against a behavioral copy of the tag store, ranks and totals.
// ----------------------------------------------------------------------------
class cache_scoreboard;
    bit          valid_q[2048];
    bit [63:0]   tag_q[2048];
    bit [2:0]    rank_q[2048];
    bit [31:0]   hits;
    bit [31:0]   misses;
    bit [31:0]   evicts;
    bit [3:0]    set_bits;
    bit [5:0]    off_bits;
    bit [3:0]    ways_reg;
    bit [103:0]  exp_data[$];
    bit          exp_last[$];
    int          errors;

    function void clear();
        for (int k = 0; k < 2048; k++)
        begin
            valid_q[k] = 0;
            tag_q[k] = 0;
            rank_q[k] = 3'(k % 8);
        end
        hits = 0;
        misses = 0;
        evicts = 0;
        set_bits = 0;
        off_bits = 0;
        ways_reg = 1;
        errors = 0;
    endfunction

    function bit [31:0] sat(bit [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 1;
    endfunction

    function void promote(int base, int w, int ways);
        bit [2:0] r;
        r = rank_q[base + w];
        for (int i = 0; i < ways; i++)
            if (i != w && rank_q[base + i] < r)
                rank_q[base + i]++;
        rank_q[base + w] = 0;
    endfunction

    function bit [1:0] lookup(bit [63:0] a);
        int s;
        int b;
        int ways;
        int base;
        int victim;
        bit [63:0] set;
        bit [63:0] tag;
        s = (set_bits > 8) ? 8 : set_bits;
        b = off_bits;
        ways = (ways_reg < 1) ? 1 : (ways_reg > 8) ? 8 : ways_reg;
        set = (a >> b) & ((64'd1 << s) - 1);
        tag = (s + b >= 64) ? 64'd0 : (a >> (s + b));
        base = int'(set) * 8;
        for (int i = 0; i < ways; i++)
            if (valid_q[base + i] && tag_q[base + i] == tag)
            begin
                hits = sat(hits);
                promote(base, i, ways);
                return salc_pkg::OUT_HIT;
            end
        misses = sat(misses);
        for (int i = 0; i < ways; i++)
            if (!valid_q[base + i])
            begin
                valid_q[base + i] = 1;
                tag_q[base + i] = tag;
                promote(base, i, ways);
                return salc_pkg::OUT_FILL;
            end
        evicts = sat(evicts);
        victim = 0;
        for (int i = 1; i < ways; i++)
            if (rank_q[base + i] > rank_q[base + victim])
                victim = i;
        tag_q[base + victim] = tag;
        promote(base, victim, ways);
        return salc_pkg::OUT_EVICT;
    endfunction

    function void push_result(bit [1:0] oc, bit lst);
        exp_data.push_back({6'd0, evicts, misses, hits, oc});
        exp_last.push_back(lst);
    endfunction

    function void note_access(bit [1:0] op, bit [63:0] a);
        if (op == salc_pkg::OP_UNDEF)
            return;
        push_result(lookup(a), op != salc_pkg::OP_MODIFY);
        if (op == salc_pkg::OP_MODIFY)
            push_result(lookup(a), 1);
    endfunction

    function void check_word(bit [103:0] d, bit lst);
        bit [103:0] e;
        bit el;
        if (exp_data.size() == 0)
        begin
            $display("%0t unexpected word: expected none, actual %h last %b", $time, d, lst);
            errors++;
            return;
        end
        e = exp_data.pop_front();
        el = exp_last.pop_front();
        if (d[1:0] != e[1:0])
        begin
            $display("%0t outcome: expected %0d, actual %0d", $time, e[1:0], d[1:0]);
            errors++;
        end
        if (d[33:2] != e[33:2])
        begin
            $display("%0t hit_total: expected %0d, actual %0d", $time, e[33:2], d[33:2]);
            errors++;
        end
        if (d[65:34] != e[65:34])
        begin
            $display("%0t miss_total: expected %0d, actual %0d", $time, e[65:34], d[65:34]);
            errors++;
        end
        if (d[97:66] != e[97:66])
        begin
            $display("%0t eviction_total: expected %0d, actual %0d", $time,
                     e[97:66], d[97:66]);
            errors++;
        end
        if (lst != el)
        begin
            $display("%0t last: expected %b, actual %b", $time, el, lst);
            errors++;
        end
    endfunction
endclass

module tb;
    import salc_pkg::*;

    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [71:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [103:0] m_tdata;
    logic         m_tlast;
    logic         psel = 0;
    logic         penable = 0;
    logic         pwrite = 0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    cache_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_req = 0;
    bit  hold_done = 0;
    int  hold_left = 0;
    bit  [63:0] recent_addr[$];

    set_associative_lru_cache_model_core u_top (.*);

    always #1 clk = ~clk;

    initial
    begin
        #40_000_000;
        $display("FAIL set_associative_lru_cache_model_core");
        $finish;
    end

    // receiver: random stalls plus one long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata, m_tlast);
        if (hold_req && !hold_done)
        begin
            hold_done <= 1;
            hold_left <= 400;
            m_tready <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (idx == REG_SET_BITS)
            sb.set_bits = val[3:0];
        else if (idx == REG_OFF_BITS)
            sb.off_bits = val[5:0];
        else
            sb.ways_reg = val[3:0];
    endtask

    task automatic configure(int s, int b, int w);
        reg_write(REG_SET_BITS, s);
        reg_write(REG_OFF_BITS, b);
        reg_write(REG_WAYS, w);
    endtask

    // tvalid stays up after a word is taken until the next word or a drain
    task automatic send_word(logic [1:0] op, logic [63:0] a);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {6'd0, a, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_access(op, a);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (sb.exp_data.size() != 0)
            @(posedge clk);
        // op 3 words and the last item may still be in flight
        repeat (60) @(posedge clk);
    endtask

    // mostly reuse of recent addresses so sets fill, hit and evict
    function automatic logic [63:0] pick_addr(int s, int b);
        logic [63:0] a;
        int r;
        r = $urandom_range(99);
        if (r < 55 && recent_addr.size() > 0)
            a = recent_addr[$urandom_range(recent_addr.size() - 1)];
        else if (r < 85)
        begin
            a = {$urandom(), $urandom()};
            a = (a & ((64'd1 << (s + b)) - 1)) | (64'($urandom_range(5)) << (s + b));
        end
        else
            a = {$urandom(), $urandom()};
        recent_addr.push_back(a);
        if (recent_addr.size() > 24)
            void'(recent_addr.pop_front());
        return a;
    endfunction

    function automatic logic [1:0] pick_op();
        int r;
        r = $urandom_range(99);
        return (r < 35) ? OP_LOAD : (r < 65) ? OP_STORE : (r < 95) ? OP_MODIFY : OP_UNDEF;
    endfunction

    initial
    begin
        int cfg_s[6] = '{0, 2, 8, 12, 3, 1};
        int cfg_b[6] = '{0, 4, 56, 63, 6, 60};
        int cfg_w[6] = '{1, 4, 8, 0, 15, 2};
        sb = new();
        sb.clear();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;

        // directed: extremes, every op, undefined op, duplicate and wide splits
        configure(2, 4, 2);
        send_word(OP_LOAD, 64'd0);
        send_word(OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(OP_MODIFY, 64'h0000_0000_0000_0100);
        send_word(OP_UNDEF, 64'h5555_5555_5555_5555);
        send_word(OP_LOAD, 64'h0000_0000_0000_0200);
        send_word(OP_LOAD, 64'd0);
        send_word(OP_STORE, 64'hAAAA_AAAA_AAAA_AAAA);
        send_word(OP_MODIFY, 64'h5555_5555_5555_5555);
        drain();
        // shrink to one way then widen: stale lines beyond E stay untouched
        configure(2, 4, 1);
        send_word(OP_LOAD, 64'h0000_0000_0000_0200);
        send_word(OP_LOAD, 64'h0000_0000_0000_0300);
        drain();
        configure(2, 4, 4);
        send_word(OP_LOAD, 64'h0000_0000_0000_0200);
        send_word(OP_MODIFY, 64'h0000_0000_0000_0300);
        drain();
        configure(15, 63, 9);
        send_word(OP_LOAD, 64'h8000_0000_0000_0000);
        send_word(OP_MODIFY, 64'h1234_5678_9ABC_DEF0);
        send_word(OP_STORE, 64'd1);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            configure(cfg_s[ph], cfg_b[ph], cfg_w[ph]);
            recent_addr.delete();
            for (int n = 0; n < 320; n++)
            begin
                case (n)
                    0:   begin send_idle_pct = 31; recv_idle_pct = 55; end
                    110: begin send_idle_pct = 55; recv_idle_pct = 31; end
                    220: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                    default: ;
                endcase
                if (ph == 1 && n == 250)
                    hold_req = 1;
                send_word(pick_op(), pick_addr(cfg_s[ph] > 8 ? 8 : cfg_s[ph],
                                               cfg_b[ph]));
            end
            drain();
        end

        if (sb.errors == 0 && sb.exp_data.size() == 0)
            $display("PASS set_associative_lru_cache_model_core");
        else
            $display("FAIL set_associative_lru_cache_model_core");
        $finish;
    end
endmodule
